/* sv/rti_pkg.sv */
// ---------------------------------------------------------------------------
// rti_pkg
// Shared constants and types of the ray / triangle intersection core.
// ---------------------------------------------------------------------------
package rti_pkg;

	// default coordinate width in bits (signed fixed point)
	localparam int COORD_WIDTH_DEF = 16;

	// distance format: unsigned Q16.16
	localparam int DIST_BITS = 32;
	localparam int DIST_FRAC = 16;

	// cycles the geometry cache needs after a vertex write
	localparam int CACHE_LAT = 5;

	// configuration port
	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 5;

	typedef enum logic [1:0] {
		REG_VERTEX_A = 2'd0,
		REG_VERTEX_B = 2'd1,
		REG_VERTEX_C = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_BEHIND   = 2'd2,
		ST_OUTSIDE  = 2'd3
	} status_t;

endpackage

/* sv/ray_triangle_intersect_core.sv */
// ---------------------------------------------------------------------------
// ray_triangle_intersect_core
// Plane / barycentric ray-triangle test against a cached triangle, with a
// bit-per-stage pipelined divider for the distance.
// ---------------------------------------------------------------------------
// An accepted request passes 7 geometry stages, 32 divider stages and one
// output register on its way to the done strobe. Throughput: one request
// per cycle while busy is low; results cannot be stalled. busy is high
// after reset and after each vertex write while the edge, normal and plane
// offset cache refills; all of it clears on arst_n.

module ray_triangle_intersect_core #(
	parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// apb configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [rti_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [rti_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [rti_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready,
	// request
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_WIDTH-1:0]         origin_x,
	input  logic signed [COORD_WIDTH-1:0]         origin_y,
	input  logic signed [COORD_WIDTH-1:0]         origin_z,
	input  logic signed [COORD_WIDTH-1:0]         dir_x,
	input  logic signed [COORD_WIDTH-1:0]         dir_y,
	input  logic signed [COORD_WIDTH-1:0]         dir_z,
	// result
	output logic                                  done,
	output logic [1:0]                            status,
	output logic                                  hit,
	output logic [rti_pkg::DIST_BITS-1:0]         distance
);

	localparam int W   = COORD_WIDTH;
	localparam int VW  = 3 * W;
	localparam int EW  = W + 1;
	localparam int NPW = 2 * EW;
	localparam int NW  = NPW + 1;
	localparam int AW  = NW + W + 4;
	localparam int DPW = NW + W;
	localparam int MPW = W + EW;
	localparam int MW  = MPW + 1;
	localparam int UPW = EW + MW;
	localparam int QW  = rti_pkg::DIST_BITS;
	localparam int FR  = rti_pkg::DIST_FRAC;
	localparam int CW  = $clog2(rti_pkg::CACHE_LAT + 1);

	// apb register file
	logic [VW-1:0]      vtx_a_q, vtx_b_q, vtx_c_q;
	logic               cfg_wr;
	rti_pkg::reg_idx_t  cfg_idx;
	logic [CW-1:0]      cache_cnt_q;

	assign pready  = 1'b1;
	assign cfg_idx = rti_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q     <= '0;
			vtx_b_q     <= '0;
			vtx_c_q     <= '0;
			cache_cnt_q <= CW'(rti_pkg::CACHE_LAT);
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					rti_pkg::REG_VERTEX_A: vtx_a_q <= pwdata[VW-1:0];
					rti_pkg::REG_VERTEX_B: vtx_b_q <= pwdata[VW-1:0];
					rti_pkg::REG_VERTEX_C: vtx_c_q <= pwdata[VW-1:0];
					default: ;
				endcase
			end
			if (cfg_wr && cfg_idx != rti_pkg::REG_NONE)
				cache_cnt_q <= CW'(rti_pkg::CACHE_LAT);
			else if (cache_cnt_q != '0)
				cache_cnt_q <= cache_cnt_q - CW'(1);
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			rti_pkg::REG_VERTEX_A: prdata = rti_pkg::APB_DATA_BITS'(vtx_a_q);
			rti_pkg::REG_VERTEX_B: prdata = rti_pkg::APB_DATA_BITS'(vtx_b_q);
			rti_pkg::REG_VERTEX_C: prdata = rti_pkg::APB_DATA_BITS'(vtx_c_q);
			default:               prdata = '0;
		endcase
	end

	assign busy = (cache_cnt_q != '0);

	// unpacked vertex coordinates
	logic signed [W-1:0] va [3];
	logic signed [W-1:0] vb [3];
	logic signed [W-1:0] vc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = signed'(vtx_a_q[i*W +: W]);
			vb[i] = signed'(vtx_b_q[i*W +: W]);
			vc[i] = signed'(vtx_c_q[i*W +: W]);
		end
	end

	// geometry cache: edges, normal, plane offset (free running)
	logic signed [EW-1:0]  e0_q [3];
	logic signed [EW-1:0]  e1_q [3];
	logic signed [NPW-1:0] np_q [3][2];
	logic signed [NW-1:0]  nrm_q [3];
	logic signed [DPW-1:0] op_q [3];
	logic signed [AW-1:0]  off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				e0_q[i]    <= '0;
				e1_q[i]    <= '0;
				np_q[i][0] <= '0;
				np_q[i][1] <= '0;
				nrm_q[i]   <= '0;
				op_q[i]    <= '0;
			end
			off_q <= '0;
		end else begin
			for (int i = 0; i < 3; i++) begin
				e0_q[i]    <= EW'(vc[i]) - EW'(va[i]);
				e1_q[i]    <= EW'(vb[i]) - EW'(va[i]);
				// n = e1 x e0
				np_q[i][0] <= NPW'(e1_q[(i+1)%3]) * NPW'(e0_q[(i+2)%3]);
				np_q[i][1] <= NPW'(e1_q[(i+2)%3]) * NPW'(e0_q[(i+1)%3]);
				nrm_q[i]   <= NW'(np_q[i][0]) - NW'(np_q[i][1]);
				op_q[i]    <= DPW'(nrm_q[i]) * DPW'(va[i]);
			end
			off_q <= AW'(op_q[0]) + AW'(op_q[1]) + AW'(op_q[2]);
		end
	end

	// ---------------------------------------------------------------------
	// ray pipeline
	// ---------------------------------------------------------------------
	logic acc;
	assign acc = start && !busy;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [W-1:0]   o_s1 [3];
	logic signed [W-1:0]   d_s1 [3];
	logic signed [EW-1:0]  sv_s1 [3];
	logic signed [DPW-1:0] nd_s2 [3];
	logic signed [DPW-1:0] no_s2 [3];
	logic signed [MPW-1:0] m1p_s2 [3][2];
	logic signed [MPW-1:0] m2p_s2 [3][2];
	logic signed [EW-1:0]  sv_s2 [3];
	logic signed [AW-1:0]  den_s3, nos_s3;
	logic signed [MW-1:0]  m1_s3 [3];
	logic signed [MW-1:0]  m2_s3 [3];
	logic signed [EW-1:0]  sv_s3 [3];
	logic signed [AW-1:0]  den_s4, num_s4;
	logic signed [UPW-1:0] up_s4 [3];
	logic signed [UPW-1:0] vp_s4 [3];
	logic signed [AW-1:0]  den_s5, num_s5, u_s5, v_s5;
	logic signed [AW-1:0]  den_s6, num_s6, u_s6, v_s6;
	logic                  dz_s6;
	rti_pkg::status_t      st_s7;
	logic                  sat_s7;
	logic [AW-1:0]         rem_s7, den_s7;
	logic [QW-1:0]         x_s7;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// status and saturation of stage 6 data
	logic signed [AW:0]      uv_sum;
	logic signed [AW+FR-1:0] num_ext, den_shl;
	rti_pkg::status_t        st_nxt;

	always_comb begin
		uv_sum  = (AW+1)'(u_s6) + (AW+1)'(v_s6);
		num_ext = (AW+FR)'(num_s6);
		den_shl = (AW+FR)'(den_s6) <<< FR;
		if (dz_s6)
			st_nxt = rti_pkg::ST_PARALLEL;
		else if (num_s6 < 0)
			st_nxt = rti_pkg::ST_BEHIND;
		else if (u_s6 < 0 || v_s6 < 0 || !(uv_sum < (AW+1)'(den_s6)))
			st_nxt = rti_pkg::ST_OUTSIDE;
		else
			st_nxt = rti_pkg::ST_HIT;
	end

	// data path stages 1 to 7
	always_ff @(posedge clk) begin
		// s1: capture ray, s = o - a
		o_s1[0] <= origin_x;
		o_s1[1] <= origin_y;
		o_s1[2] <= origin_z;
		d_s1[0] <= dir_x;
		d_s1[1] <= dir_y;
		d_s1[2] <= dir_z;
		sv_s1[0] <= EW'(origin_x) - EW'(va[0]);
		sv_s1[1] <= EW'(origin_y) - EW'(va[1]);
		sv_s1[2] <= EW'(origin_z) - EW'(va[2]);
		for (int i = 0; i < 3; i++) begin
			// s2: products for n.d, n.o, d x e1, d x s
			nd_s2[i]     <= DPW'(nrm_q[i]) * DPW'(d_s1[i]);
			no_s2[i]     <= DPW'(nrm_q[i]) * DPW'(o_s1[i]);
			m1p_s2[i][0] <= MPW'(d_s1[(i+1)%3]) * MPW'(e1_q[(i+2)%3]);
			m1p_s2[i][1] <= MPW'(d_s1[(i+2)%3]) * MPW'(e1_q[(i+1)%3]);
			m2p_s2[i][0] <= MPW'(d_s1[(i+1)%3]) * MPW'(sv_s1[(i+2)%3]);
			m2p_s2[i][1] <= MPW'(d_s1[(i+2)%3]) * MPW'(sv_s1[(i+1)%3]);
			sv_s2[i]     <= sv_s1[i];
			// s3: cross product components
			m1_s3[i] <= MW'(m1p_s2[i][0]) - MW'(m1p_s2[i][1]);
			m2_s3[i] <= MW'(m2p_s2[i][0]) - MW'(m2p_s2[i][1]);
			sv_s3[i] <= sv_s2[i];
			// s4: products for u and v
			up_s4[i] <= UPW'(sv_s3[i]) * UPW'(m1_s3[i]);
			vp_s4[i] <= UPW'(e0_q[i]) * UPW'(m2_s3[i]);
		end
		den_s3 <= AW'(nd_s2[0]) + AW'(nd_s2[1]) + AW'(nd_s2[2]);
		nos_s3 <= AW'(no_s2[0]) + AW'(no_s2[1]) + AW'(no_s2[2]);
		den_s4 <= den_s3;
		num_s4 <= off_q - nos_s3;
		// s5: u and v sums
		den_s5 <= den_s4;
		num_s5 <= num_s4;
		u_s5   <= AW'(up_s4[0]) + AW'(up_s4[1]) + AW'(up_s4[2]);
		v_s5   <= AW'(vp_s4[0]) + AW'(vp_s4[1]) + AW'(vp_s4[2]);
		// s6: fold sign of the denominator
		dz_s6 <= (den_s5 == '0);
		if (den_s5 < 0) begin
			den_s6 <= -den_s5;
			num_s6 <= -num_s5;
			u_s6   <= -u_s5;
			v_s6   <= -v_s5;
		end else begin
			den_s6 <= den_s5;
			num_s6 <= num_s5;
			u_s6   <= u_s5;
			v_s6   <= v_s5;
		end
		// s7: classify, saturation, divider set-up
		st_s7  <= st_nxt;
		sat_s7 <= !(num_ext < den_shl);
		rem_s7 <= {{FR{1'b0}}, num_s6[AW-1:FR]};
		x_s7   <= {num_s6[FR-1:0], {(QW-FR){1'b0}}};
		den_s7 <= unsigned'(den_s6);
	end

	// ---------------------------------------------------------------------
	// restoring divider, one quotient bit per stage
	// ---------------------------------------------------------------------
	logic                 dv_vld_s [QW+1];
	logic [AW-1:0]        dv_rem_s [QW+1];
	logic [AW-1:0]        dv_den_s [QW+1];
	logic [QW-1:0]        dv_x_s   [QW+1];
	logic [QW-1:0]        dv_q_s   [QW+1];
	rti_pkg::status_t     dv_st_s  [QW+1];
	logic                 dv_sat_s [QW+1];

	assign dv_vld_s[0] = vld_s7;
	assign dv_rem_s[0] = rem_s7;
	assign dv_den_s[0] = den_s7;
	assign dv_x_s[0]   = x_s7;
	assign dv_q_s[0]   = '0;
	assign dv_st_s[0]  = st_s7;
	assign dv_sat_s[0] = sat_s7;

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [AW:0] trial;
		logic [AW:0] diff;

		assign trial = {dv_rem_s[j], dv_x_s[j][QW-1]};
		assign diff  = trial - {1'b0, dv_den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[j+1] <= 1'b0;
			else
				dv_vld_s[j+1] <= dv_vld_s[j];
		end

		// trial subtract, keep the remainder when it fits
		always_ff @(posedge clk) begin
			if (!diff[AW]) begin
				dv_rem_s[j+1] <= diff[AW-1:0];
				dv_q_s[j+1]   <= {dv_q_s[j][QW-2:0], 1'b1};
			end else begin
				dv_rem_s[j+1] <= trial[AW-1:0];
				dv_q_s[j+1]   <= {dv_q_s[j][QW-2:0], 1'b0};
			end
			dv_den_s[j+1] <= dv_den_s[j];
			dv_x_s[j+1]   <= {dv_x_s[j][QW-2:0], 1'b0};
			dv_st_s[j+1]  <= dv_st_s[j];
			dv_sat_s[j+1] <= dv_sat_s[j];
		end
	end

	// output register
	logic                 done_q, hit_q;
	rti_pkg::status_t     status_q;
	logic [QW-1:0]        distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= dv_vld_s[QW];
	end

	always_ff @(posedge clk) begin
		status_q <= dv_st_s[QW];
		hit_q    <= (dv_st_s[QW] == rti_pkg::ST_HIT);
		if (dv_st_s[QW] != rti_pkg::ST_HIT)
			distance_q <= '0;
		else if (dv_sat_s[QW])
			distance_q <= '1;
		else
			distance_q <= dv_q_s[QW];
	end

	assign done     = done_q;
	assign status   = status_q;
	assign hit      = hit_q;
	assign distance = distance_q;

endmodule

/* sim/rti_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rti_checker
// Watches the vertex register port, the request channel and the result
// strobe of the ray / triangle core. Keeps its own copy of the triangle
// geometry, predicts status, hit flag and distance for every accepted
// request and compares each result against the oldest prediction.
// ---------------------------------------------------------------------------
module rti_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rti_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [rti_pkg::APB_DATA_BITS-1:0] pwdata,
	input  logic                              pready,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [15:0]                origin_x,
	input  logic signed [15:0]                origin_y,
	input  logic signed [15:0]                origin_z,
	input  logic signed [15:0]                dir_x,
	input  logic signed [15:0]                dir_y,
	input  logic signed [15:0]                dir_z,
	input  logic                              done,
	input  logic [1:0]                        status,
	input  logic                              hit,
	input  logic [31:0]                       distance,
	output int                                errors,
	output int                                pending
);

	typedef logic signed [127:0] wide_t;
	typedef wide_t vec_t [3];

	typedef struct {
		rti_pkg::status_t st;
		logic             hit;
		logic [31:0]      t_dist;
	} outcome_t;

	outcome_t outcome_q [$];
	logic [47:0] vtx [3];
	vec_t corner_a, edge_ca, edge_ba, nrm;
	wide_t plane_off;

	function automatic vec_t unpack_vtx(input logic [47:0] r);
		vec_t v;
		for (int i = 0; i < 3; i++)
			v[i] = wide_t'($signed(r[i*16 +: 16]));
		return v;
	endfunction

	function automatic vec_t cross_p(input vec_t p, input vec_t q);
		vec_t r;
		r[0] = p[1] * q[2] - p[2] * q[1];
		r[1] = p[2] * q[0] - p[0] * q[2];
		r[2] = p[0] * q[1] - p[1] * q[0];
		return r;
	endfunction

	function automatic wide_t dot_p(input vec_t p, input vec_t q);
		return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
	endfunction

	// refresh edges, normal and plane offset from the vertex copies
	function automatic void refresh_geometry();
		vec_t b, c;
		corner_a = unpack_vtx(vtx[0]);
		b = unpack_vtx(vtx[1]);
		c = unpack_vtx(vtx[2]);
		for (int i = 0; i < 3; i++) begin
			edge_ca[i] = c[i] - corner_a[i];
			edge_ba[i] = b[i] - corner_a[i];
		end
		nrm = cross_p(edge_ba, edge_ca);
		plane_off = dot_p(nrm, corner_a);
	endfunction

	// plane distance plus barycentric inside test, all exact
	function automatic outcome_t intersect_ray(input vec_t o, input vec_t d);
		outcome_t r;
		wide_t den, num, u, v;
		vec_t s, m;
		r.st = rti_pkg::ST_PARALLEL;
		r.hit = 1'b0;
		r.t_dist = '0;
		den = dot_p(nrm, d);
		if (den != 0) begin
			num = plane_off - dot_p(nrm, o);
			for (int i = 0; i < 3; i++)
				s[i] = o[i] - corner_a[i];
			m = cross_p(d, edge_ba);
			u = dot_p(s, m);
			m = cross_p(d, s);
			v = dot_p(edge_ca, m);
			if (den < 0) begin
				den = -den;
				num = -num;
				u = -u;
				v = -v;
			end
			if (num < 0)
				r.st = rti_pkg::ST_BEHIND;
			else if (u < 0 || v < 0 || u + v >= den)
				r.st = rti_pkg::ST_OUTSIDE;
			else begin
				r.st = rti_pkg::ST_HIT;
				r.hit = 1'b1;
				if (num >= (den <<< rti_pkg::DIST_FRAC))
					r.t_dist = 32'hFFFF_FFFF;
				else
					r.t_dist = 32'((num <<< rti_pkg::DIST_FRAC) / den);
			end
		end
		return r;
	endfunction

	assign pending = outcome_q.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_r;
		vec_t o, d;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				vtx[i] = '0;
			refresh_geometry();
			outcome_q.delete();
			errors = 0;
		end else begin
			// vertex register writes
			if (psel && penable && pwrite && pready && (paddr >> 3) < rti_pkg::REG_NONE) begin
				vtx[paddr >> 3] = pwdata[47:0];
				refresh_geometry();
			end
			// accepted request
			if (start && !busy) begin
				o[0] = origin_x;
				o[1] = origin_y;
				o[2] = origin_z;
				d[0] = dir_x;
				d[1] = dir_y;
				d[2] = dir_z;
				outcome_q.push_back(intersect_ray(o, d));
			end
			// result strobe
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					exp_r = outcome_q.pop_front();
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						errors++;
					end
					if (hit !== exp_r.hit) begin
						$error("hit expected %0d actual %0d", exp_r.hit, hit);
						errors++;
					end
					if (distance !== exp_r.t_dist) begin
						$error("distance expected %h actual %h", exp_r.t_dist, distance);
						errors++;
					end
				end
			end
		end
	end

endmodule

/* sim/tb_ray_triangle_intersect_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ray_triangle_intersect_core
// Drives vertex writes and ray requests into the intersection core: a
// directed set of corner cases, then random rays, most of them aimed at a
// point inside the current triangle, over several triangles.
// ---------------------------------------------------------------------------
module tb_ray_triangle_intersect_core;

	localparam int N_RANDOM = 600;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                psel = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite = 1'b0;
	logic [rti_pkg::APB_ADDR_BITS-1:0]   paddr = '0;
	logic [rti_pkg::APB_DATA_BITS-1:0]   pwdata = '0;
	logic [rti_pkg::APB_DATA_BITS-1:0]   prdata;
	logic                                pready;
	logic                                start = 1'b0;
	logic                                busy;
	logic signed [15:0]                  origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [15:0]                  dir_x = '0, dir_y = '0, dir_z = '0;
	logic                                done;
	logic [1:0]                          status;
	logic                                hit;
	logic [31:0]                         distance;
	int                                  errors;
	int                                  pending;

	// current triangle as plain integers, used to aim rays
	int tri_v [3][3];

	always #6 clk = ~clk;

	ray_triangle_intersect_core u_dut (.*);

	rti_checker u_chk (.*);

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// one request, held until accepted
	task automatic send_ray(input int ox, oy, oz, dx, dy, dz);
		@(negedge clk);
		start <= 1'b1;
		origin_x <= 16'(ox);
		origin_y <= 16'(oy);
		origin_z <= 16'(oz);
		dir_x <= 16'(dx);
		dir_y <= 16'(dy);
		dir_z <= 16'(dz);
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// sender holds off until every outstanding request has its result
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input rti_pkg::reg_idx_t idx, input logic [63:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= rti_pkg::APB_ADDR_BITS'(idx) << 3;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write one vertex; the upper 16 bits carry junk that must be ignored
	task automatic set_vertex(input rti_pkg::reg_idx_t idx, input int x, y, z);
		reg_write(idx, {16'($urandom), 16'(z), 16'(y), 16'(x)});
		tri_v[idx][0] = x;
		tri_v[idx][1] = y;
		tri_v[idx][2] = z;
	endtask

	task automatic set_triangle(input int ax, ay, az, bx, by, bz, cx, cy, cz);
		drain();
		set_vertex(rti_pkg::REG_VERTEX_A, ax, ay, az);
		set_vertex(rti_pkg::REG_VERTEX_B, bx, by, bz);
		set_vertex(rti_pkg::REG_VERTEX_C, cx, cy, cz);
	endtask

	function automatic int clamp16(input int x);
		return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
	endfunction

	function automatic int rnd_coord(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// ray aimed at a random point inside the triangle, or away from it
	task automatic send_aimed(input bit away);
		int uu, vv, sh;
		int p [3], o [3], d [3];
		uu = $urandom_range(0, 255);
		vv = $urandom_range(0, 255 - uu);
		sh = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			p[i] = tri_v[0][i] + ((tri_v[1][i] - tri_v[0][i]) * uu
				+ (tri_v[2][i] - tri_v[0][i]) * vv) / 256;
			o[i] = rnd_coord(12000);
			d[i] = clamp16(away ? (o[i] - p[i]) >>> sh : (p[i] - o[i]) >>> sh);
		end
		send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endtask

	task automatic random_triangle();
		drain();
		for (int r = 0; r < 3; r++)
			if (r == 0 || $urandom_range(0, 3) != 0)
				set_vertex(rti_pkg::reg_idx_t'(r), rnd_coord(12000), rnd_coord(12000),
					rnd_coord(12000));
	endtask

	initial begin
		int kind;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset triangle is degenerate
		send_ray(0, 0, 0, 256, 256, 256);
		send_ray(32767, -32768, 32767, -32768, 32767, -32768);

		// unit triangle in the z = 0 plane
		set_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0);
		send_ray(64, 64, 256, 0, 0, -256);       // hit at t = 1
		send_ray(64, 64, 256, 0, 0, 256);        // plane behind origin
		send_ray(64, 64, 256, 256, 0, 0);        // parallel
		send_ray(64, 64, 256, 0, 0, 0);          // zero direction
		send_ray(64, 64, 0, 0, 0, 1);            // origin on the plane
		send_ray(300, 300, 256, 0, 0, -256);     // outside
		send_ray(128, 128, 256, 0, 0, -256);     // on the far edge, u + v = 1
		send_ray(0, 64, 256, 0, 0, -1);          // on an edge, long t
		send_ray(32767, -32768, 32767, -32768, 32767, -32768);
		send_ray(-32768, 32767, -32768, 32767, -32768, 32767);
		send_ray(-32768, -32768, 32767, 1, 1, -1);

		// out of range register index is ignored
		drain();
		reg_write(rti_pkg::REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_ray(64, 64, 256, 0, 0, -256);

		// extreme vertices
		set_triangle(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
		send_ray(0, 0, 0, 32767, 0, 0);
		send_ray(-32768, -32768, -32768, 32767, 32767, 32767);
		send_aimed(1'b0);

		// collinear and coincident vertices
		set_triangle(0, 0, 0, 100, 100, 100, 200, 200, 200);
		send_ray(0, 0, -500, 10, 20, 30);
		set_triangle(77, -77, 5, 77, -77, 5, 77, -77, 5);
		send_ray(0, 0, -500, 10, 20, 30);

		// random part, new triangle now and then
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0)
				random_triangle();
			else if (i == 350)
				drain();
			kind = $urandom_range(0, 9);
			if (kind < 6)
				send_aimed(1'b0);
			else if (kind == 6)
				send_aimed(1'b1);
			else
				send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			if (i < N_RANDOM - 100 && $urandom_range(0, 5) == 0)
				pause($urandom_range(1, 14));
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
